// ===== rtl/aes_pkg.sv =====
// AES-128 CTR package: S-box, round constants and round helper functions.
// Used by the round cell, the key cell and the top level.
package aes_pkg;

  localparam int unsigned NumRounds = 10;
  localparam int unsigned BlockBits = 128;
  localparam int unsigned CountBits = 5;

  localparam logic [1:0] RegKeyLow   = 2'd0;
  localparam logic [1:0] RegKeyHigh  = 2'd1;
  localparam logic [1:0] RegNonce    = 2'd2;

  // Per-cycle side data that travels with a block down the cell chain.
  typedef struct packed {
    logic [63:0]          data_low;
    logic [63:0]          data_high;
    logic [CountBits-1:0] count;
  } side_t;

  function automatic logic [7:0] sbox(input logic [7:0] a);
    logic [7:0] t [256];
    t = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };
    return t[a];
  endfunction

  function automatic logic [7:0] rcon(input logic [3:0] r);
    case (r)
      4'd1:    return 8'h01;
      4'd2:    return 8'h02;
      4'd3:    return 8'h04;
      4'd4:    return 8'h08;
      4'd5:    return 8'h10;
      4'd6:    return 8'h20;
      4'd7:    return 8'h40;
      4'd8:    return 8'h80;
      4'd9:    return 8'h1b;
      4'd10:   return 8'h36;
      default: return 8'h00;
    endcase
  endfunction

  function automatic logic [7:0] xtime(input logic [7:0] b);
    return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
  endfunction

  // Byte i of a state sits in bits 8*i+7:8*i.
  function automatic logic [127:0] key_next(input logic [127:0] k, input logic [3:0] r);
    logic [31:0] t;
    logic [127:0] n;
    t = {sbox(k[103:96]), sbox(k[127:120]), sbox(k[119:112]),
         sbox(k[111:104]) ^ rcon(r)};
    n[31:0]   = k[31:0] ^ t;
    n[63:32]  = k[63:32] ^ n[31:0];
    n[95:64]  = k[95:64] ^ n[63:32];
    n[127:96] = k[127:96] ^ n[95:64];
    return n;
  endfunction

  function automatic logic [127:0] round_fn(input logic [127:0] s, input logic [127:0] rk,
                                            input logic last);
    logic [7:0] a [16];
    logic [7:0] b [16];
    logic [7:0] x;
    logic [127:0] o;
    for (int i = 0; i < 16; i++) a[i] = sbox(s[8*i +: 8]);
    for (int r = 0; r < 4; r++)
      for (int c = 0; c < 4; c++) b[r + 4*c] = a[r + 4*((c + r) % 4)];
    for (int c = 0; c < 4; c++) begin
      x = b[4*c] ^ b[4*c+1] ^ b[4*c+2] ^ b[4*c+3];
      if (last) begin
        o[32*c +: 32] = {b[4*c+3], b[4*c+2], b[4*c+1], b[4*c]};
      end else begin
        o[32*c +: 8]    = b[4*c]   ^ x ^ xtime(b[4*c]   ^ b[4*c+1]);
        o[32*c+8 +: 8]  = b[4*c+1] ^ x ^ xtime(b[4*c+1] ^ b[4*c+2]);
        o[32*c+16 +: 8] = b[4*c+2] ^ x ^ xtime(b[4*c+2] ^ b[4*c+3]);
        o[32*c+24 +: 8] = b[4*c+3] ^ x ^ xtime(b[4*c+3] ^ b[4*c]);
      end
    end
    return o ^ rk;
  endfunction

endpackage

// ===== rtl/aes_key_cell.sv =====
// AES key schedule cell: one registered round key per cell, fixed round number.
// Depends on aes_pkg.
module aes_key_cell import aes_pkg::*; #(
  parameter logic [3:0] Round = 4'd1
) (
  input  logic         clk_i,
  input  logic [127:0] key_i,
  output logic [127:0] key_o
);
  logic [127:0] key_q;

  // Derive this round's key from the previous one and register it.
  always_ff @(posedge clk_i) begin
    key_q <= key_next(key_i, Round);
  end

  assign key_o = key_q;
endmodule

// ===== rtl/aes_round_cell.sv =====
// AES round cell: one registered round with its side data and valid bit.
// Depends on aes_pkg.
module aes_round_cell import aes_pkg::*; #(
  parameter bit Last = 1'b0
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         en_i,
  input  logic         valid_i,
  input  logic [127:0] state_i,
  input  side_t        side_i,
  input  logic [127:0] rkey_i,
  output logic         valid_o,
  output logic [127:0] state_o,
  output side_t        side_o
);
  logic valid_q;
  logic [127:0] state_q;
  side_t side_q;

  // Advance the valid bit when the chain moves.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  // Hold payload while stalled.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      state_q <= round_fn(state_i, rkey_i, Last);
      side_q  <= side_i;
    end
  end

  assign valid_o = valid_q;
  assign state_o = state_q;
  assign side_o  = side_q;
endmodule

// ===== rtl/aes128_ctr_cipher.sv =====
// AES-128 counter mode block: ten round cells in a chain, key schedule in a cell chain.
// Depends on aes_pkg, aes_round_cell and aes_key_cell.
//
// One 16-byte block is taken per cycle when the chain moves and no hold-off is on;
// throughput is one block per cycle, set by the ten-cell round pipeline. The whole
// chain stalls together when the output is not taken. Each key cell registers one
// round of key expansion, so round key r settles once a new key has passed key
// cells 1 to r. The input is held off after reset and after each register write,
// which keeps every round key ahead of the block that uses it. The user must write
// registers only while nothing is in flight; the block does not enforce this.
module aes128_ctr_cipher import aes_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [1:0]           cfg_index_i,
  input  logic [63:0]          cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [63:0]          data_low_i,
  input  logic [63:0]          data_high_i,
  input  logic [CountBits-1:0] byte_count_i,
  input  logic                 first_block_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [63:0]          out_low_o,
  output logic [63:0]          out_high_o,
  output logic [CountBits-1:0] out_count_o
);
  logic [63:0] key_low_q, key_high_q, nonce_q, ctr_q;
  logic cfg_hold_q;
  logic [127:0] rkey [NumRounds+1];
  logic [127:0] st [NumRounds+1];
  side_t side [NumRounds+1];
  logic vld [NumRounds+1];
  logic en, in_xfer;
  logic [63:0] ctr_use;
  logic [127:0] dat, msk;

  // Whole chain moves when the last cell is empty or being drained.
  assign en         = !vld[NumRounds] || out_ready_i;
  assign in_ready_o = en && !cfg_hold_q;
  assign in_xfer    = in_valid_i && in_ready_o;
  assign ctr_use    = first_block_i ? 64'd0 : ctr_q;

  // Hold off input after reset and after a register write.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_hold_q <= 1'b1;
    end else begin
      cfg_hold_q <= cfg_we_i;
    end
  end

  // Write configuration registers and advance the counter on each accepted block.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_low_q  <= '0;
      key_high_q <= '0;
      nonce_q    <= '0;
      ctr_q      <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          RegKeyLow:  key_low_q  <= cfg_data_i;
          RegKeyHigh: key_high_q <= cfg_data_i;
          RegNonce:   nonce_q    <= cfg_data_i;
          default:    ;
        endcase
      end
      if (in_xfer) ctr_q <= ctr_use + 64'd1;
    end
  end

  // Expand round keys.
  assign rkey[0] = {key_high_q, key_low_q};
  for (genvar r = 1; r <= NumRounds; r++) begin : g_key
    aes_key_cell #(.Round(4'(r))) u_key (.clk_i, .key_i(rkey[r-1]), .key_o(rkey[r]));
  end

  // Feed the whitened counter block into the chain.
  assign st[0]   = {ctr_use, nonce_q} ^ rkey[0];
  assign vld[0]  = in_xfer;
  assign side[0] = '{data_low: data_low_i, data_high: data_high_i, count: byte_count_i};

  for (genvar r = 1; r <= NumRounds; r++) begin : g_round
    aes_round_cell #(.Last(r == NumRounds)) u_round (
      .clk_i, .rst_ni, .en_i(en), .valid_i(vld[r-1]), .state_i(st[r-1]),
      .side_i(side[r-1]), .rkey_i(rkey[r]), .valid_o(vld[r]), .state_o(st[r]),
      .side_o(side[r])
    );
  end

  // Mask bytes at or past the count.
  always_comb begin
    for (int i = 0; i < 16; i++)
      msk[8*i +: 8] = (CountBits'(i) < side[NumRounds].count) ? 8'hff : 8'h00;
  end
  assign dat = ({side[NumRounds].data_high, side[NumRounds].data_low} ^ st[NumRounds]) & msk;

  assign out_valid_o = vld[NumRounds];
  assign out_low_o   = dat[63:0];
  assign out_high_o  = dat[127:64];
  assign out_count_o = side[NumRounds].count;
endmodule
